/* src/lpcfs_pkg.sv */
// shared types, codes and crc function for the length-prefixed crc frame splitter
package lpcfs_pkg;

   localparam int unsigned ID_LEN_W = 8;
   localparam int unsigned MAX_LEN_W = 16;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDENTITY_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DATA_LENGTH = 1'd1;

   localparam logic [ID_LEN_W-1:0] IDENTITY_LENGTH_RESET = 8'd15;
   localparam logic [MAX_LEN_W-1:0] MAX_DATA_LENGTH_RESET = 16'd2048;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] PREAMBLE_ZEROS = 16'd4;
   localparam logic [15:0] LEN_BYTES = 16'd4;
   localparam logic [15:0] TRAILER_BYTES = 16'd4;

   localparam logic [1:0] KIND_IDENTITY = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   localparam logic [1:0] STATUS_GOOD = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef enum logic [4:0] {
      PH_IDENT   = 5'b00001,
      PH_HUNT    = 5'b00010,
      PH_LEN     = 5'b00100,
      PH_DATA    = 5'b01000,
      PH_TRAILER = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [ID_LEN_W-1:0]  identity_length;
      logic [MAX_LEN_W-1:0] max_data_length;
   } cfg_type;

   typedef struct packed {
      logic       last;
      logic [1:0] status;
      logic [1:0] kind;
      logic [7:0] out_byte;
   } result_type;

   // crc-16/arc over one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/lpcfs_csr.sv */
// configuration registers: identity length and maximum data length
module lpcfs_csr
   import lpcfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IDENTITY_LENGTH: cfg_in.identity_length = csr_wdata[ID_LEN_W-1:0];
            CSR_MAX_DATA_LENGTH: cfg_in.max_data_length = csr_wdata[MAX_LEN_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.identity_length <= IDENTITY_LENGTH_RESET;
         cfg_ff.max_data_length <= MAX_DATA_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/lpcfs_parser.sv */
// stream state machine: identity pass, preamble hunt, length, data with crc, trailer check
module lpcfs_parser
   import lpcfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       start_of_connection,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  zero_run_ff, zero_run_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [31:0] data_length_ff, data_length_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;

   phase_type   cur_phase;
   logic [15:0] cur_count;
   logic [2:0]  cur_zero;
   logic [15:0] count_inc;
   logic [31:0] length_shift;
   logic [8:0]  ident_end;

   always_comb begin
      // connection start restarts the identity packet with this byte
      cur_phase = start_of_connection ? PH_IDENT : phase_ff;
      cur_count = start_of_connection ? 16'd0 : byte_count_ff;
      cur_zero  = start_of_connection ? 3'd0 : zero_run_ff;
      count_inc = cur_count + 16'd1;
      length_shift = {data_length_ff[23:0], data_byte};
      ident_end = {1'b0, cfg.identity_length} + 9'd1;

      phase_in       = cur_phase;
      zero_run_in    = cur_zero;
      byte_count_in  = cur_count;
      data_length_in = data_length_ff;
      crc_in         = crc_ff;
      crc_high_in    = crc_high_ff;
      res_valid      = 1'b0;
      res            = '0;

      case (cur_phase)
         PH_IDENT: begin
            res_valid    = 1'b1;
            res.out_byte = data_byte;
            res.kind     = KIND_IDENTITY;
            if (cur_count >= {7'd0, ident_end}) begin
               res.last      = 1'b1;
               phase_in      = PH_HUNT;
               zero_run_in   = 3'd0;
               byte_count_in = 16'd0;
            end else begin
               byte_count_in = count_inc;
            end
         end
         PH_LEN: begin
            data_length_in = length_shift;
            byte_count_in  = count_inc;
            if (count_inc >= LEN_BYTES) begin
               byte_count_in = 16'd0;
               if (length_shift > {16'd0, cfg.max_data_length}) begin
                  phase_in    = PH_HUNT;
                  zero_run_in = 3'd0;
                  res_valid   = 1'b1;
                  res.kind    = KIND_END;
                  res.status  = STATUS_TOO_LONG;
                  res.last    = 1'b1;
               end else begin
                  crc_in   = 16'd0;
                  phase_in = (length_shift == 32'd0) ? PH_TRAILER : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            crc_in        = crc_byte(crc_ff, data_byte);
            byte_count_in = count_inc;
            if ({16'd0, count_inc} >= data_length_ff) begin
               byte_count_in = 16'd0;
               phase_in      = PH_TRAILER;
            end
            res_valid    = 1'b1;
            res.out_byte = data_byte;
            res.kind     = KIND_DATA;
         end
         PH_TRAILER: begin
            byte_count_in = count_inc;
            if (count_inc == TRAILER_BYTES - 16'd1) begin
               crc_high_in = data_byte;
            end else if (count_inc >= TRAILER_BYTES) begin
               // upper half of the trailer is ignored
               phase_in      = PH_HUNT;
               zero_run_in   = 3'd0;
               byte_count_in = 16'd0;
               res_valid     = 1'b1;
               res.kind      = KIND_END;
               res.status    = ({crc_high_ff, data_byte} == crc_ff) ? STATUS_GOOD
                                                                    : STATUS_CRC_BAD;
               res.last      = 1'b1;
            end
         end
         PH_HUNT: begin
            if (data_byte == 8'd0) begin
               zero_run_in = cur_zero + 3'd1;
               if ({13'd0, zero_run_in} >= PREAMBLE_ZEROS) begin
                  zero_run_in    = 3'd0;
                  phase_in       = PH_LEN;
                  byte_count_in  = 16'd0;
                  data_length_in = 32'd0;
               end
            end else begin
               zero_run_in = 3'd0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDENT;
         zero_run_ff    <= 3'd0;
         byte_count_ff  <= 16'd0;
         data_length_ff <= 32'd0;
         crc_ff         <= 16'd0;
         crc_high_ff    <= 8'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         zero_run_ff    <= zero_run_in;
         byte_count_ff  <= byte_count_in;
         data_length_ff <= data_length_in;
         crc_ff         <= crc_in;
         crc_high_ff    <= crc_high_in;
      end
   end

endmodule

/* src/lpcfs_out_reg.sv */
// result register between the parser and the response channel
module lpcfs_out_reg
   import lpcfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output result_type rsp_data,
   output logic       space
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data = data_ff;

endmodule

/* src/length_prefixed_crc_frame_splitter.sv */
// top level of the length-prefixed crc frame splitter
//
// usage
//  - req channel: one received byte per request; tuser set marks the start of a
//    connection, whose first byte begins the identity packet
//  - rsp channel: identity bytes, frame data bytes and frame end results; tuser
//    carries kind and status, tlast marks the last identity byte and every frame end
//  - csr port: write identity_length (index 0) and max_data_length (index 1) while idle
//  - a result is registered and appears on rsp in the cycle after its request
//  - throughput: one request per cycle unless rsp stalls; the single result register sets
//    this, and it refills in the same cycle that its content is taken
//  - bytes that cause no result (preamble hunt, length, trailer) are simply consumed
//  - when the receiver stalls with a result waiting, req_tready drops until it drains
//  - reset puts the block in the identity phase with counters and crc cleared, the
//    result register empty and both config registers at their defaults (15, 2048)
//  - an over-long length ends the frame with status too long and hunting restarts
module length_prefixed_crc_frame_splitter
   import lpcfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tuser,   // [0] start_of_connection
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] out_byte
   output logic [3:0]             rsp_tuser,   // [1:0] kind, [3:2] status
   output logic                   rsp_tlast,
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   logic       req_fire;
   logic       res_valid;
   result_type res;
   result_type rsp_data;
   logic       space;

   lpcfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // request is taken whenever the result register is empty or being drained
   assign req_tready = space;
   assign req_fire = req_tvalid && req_tready;

   lpcfs_parser u_parser (
      .clock               (clock),
      .reset               (reset),
      .accept              (req_fire),
      .data_byte           (req_tdata),
      .start_of_connection (req_tuser),
      .cfg                 (cfg),
      .res_valid           (res_valid),
      .res                 (res)
   );

   lpcfs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire && res_valid),
      .load_data  (res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_data),
      .space      (space)
   );

   assign rsp_tdata = rsp_data.out_byte;
   assign rsp_tuser = {rsp_data.status, rsp_data.kind};
   assign rsp_tlast = rsp_data.last;

   // frame end results always close with last and a zero byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_END |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("frame end result without last or with nonzero byte");

   // data results never carry a status or last
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_DATA |-> rsp_tuser[3:2] == STATUS_GOOD && !rsp_tlast)
      else $error("data result with status or last");

   // an empty result register never holds off requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   // a request that makes a result shows up on rsp in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire && res_valid |=> rsp_tvalid)
      else $error("result lost after request");

endmodule

/* dv/tb_length_prefixed_crc_frame_splitter.sv */
// self-checking testbench for the length-prefixed crc frame splitter
module tb_length_prefixed_crc_frame_splitter;
   import lpcfs_pkg::*;

   // generous watchdog, far above the slowest legal run
   localparam int CYCLE_LIMIT = 400000;
   // result shows up in the cycle after its request; the spare cycles here cover it
   localparam int DRAIN_CYCLES = 4;
   // long receiver hold-off used to fill the block and stall its input
   localparam int HOLD_CYCLES = 300;
   // keep count that sends a frame or identity packet whole
   localparam int WHOLE = 1 << 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;    // [7:0] data_byte
   logic                   req_tuser = 1'b0;     // [0] start_of_connection
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;            // [7:0] out_byte
   logic [3:0]             rsp_tuser;            // [1:0] kind, [3:2] status
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IDENTITY_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   length_prefixed_crc_frame_splitter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // mirror of the config registers, updated when the write lands
   logic [ID_LEN_W-1:0]  cfg_identity_length = IDENTITY_LENGTH_RESET;
   logic [MAX_LEN_W-1:0] cfg_max_data_length = MAX_DATA_LENGTH_RESET;

   // splitter state as the predictor tracks it, reset values
   phase_type   model_phase = PH_IDENT;
   logic [2:0]  model_zero_run = '0;
   logic [15:0] model_count = '0;
   logic [31:0] model_length = '0;
   logic [15:0] model_crc = '0;
   logic [7:0]  model_crc_high = '0;

   // results the splitter still owes us, oldest first
   result_type expected_outputs[$];
   result_type expected_head;

   int mismatch_count = 0;
   int cycles_run = 0;
   // requests accepted so far
   int items_sent = 0;

   // idling knobs, percent of cycles
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   // receiver hold-off: a nonzero pulse here starts a long stall
   int rsp_hold_len = 0;
   int hold_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // crc-16/arc, reflected, one byte
   function automatic logic [15:0] crc16_arc_update(input logic [15:0] crc_in,
                                                     input logic [7:0] b);
      logic [15:0] acc;
      acc = crc_in ^ {8'h00, b};
      repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      return acc;
   endfunction

   function automatic void restart_hunt();
      model_phase = PH_HUNT;
      model_zero_run = '0;
      model_count = '0;
   endfunction

   // advance the splitter state by one request, queue the result it causes
   function automatic void predict_splitter_byte(input logic [7:0] b, input logic soc);
      result_type res;
      bit produce;
      res = '0;
      produce = 1'b0;
      // connection start wins over whatever phase we were in
      if (soc) begin
         model_phase = PH_IDENT;
         model_count = '0;
         model_zero_run = '0;
      end
      case (model_phase)
         PH_IDENT: begin
            res.out_byte = b;
            res.kind = KIND_IDENTITY;
            produce = 1'b1;
            // 2 length bytes plus identity_length bytes, last one flagged
            if (32'(model_count) >= 32'(cfg_identity_length) + 32'd1) begin
               res.last = 1'b1;
               restart_hunt();
            end else begin
               model_count = model_count + 16'd1;
            end
         end
         PH_LEN: begin
            // big-endian length
            model_length = {model_length[23:0], b};
            model_count = model_count + 16'd1;
            if (model_count >= LEN_BYTES) begin
               model_count = '0;
               if (model_length > 32'(cfg_max_data_length)) begin
                  res.kind = KIND_END;
                  res.status = STATUS_TOO_LONG;
                  res.last = 1'b1;
                  produce = 1'b1;
                  restart_hunt();
               end else begin
                  model_crc = '0;
                  if (model_length == 32'd0) begin
                     model_phase = PH_TRAILER;
                  end else begin
                     model_phase = PH_DATA;
                  end
               end
            end
         end
         PH_DATA: begin
            model_crc = crc16_arc_update(model_crc, b);
            model_count = model_count + 16'd1;
            if (32'(model_count) >= model_length) begin
               model_count = '0;
               model_phase = PH_TRAILER;
            end
            res.out_byte = b;
            res.kind = KIND_DATA;
            produce = 1'b1;
         end
         PH_TRAILER: begin
            // upper trailer half is ignored, only the low 16 bits matter
            model_count = model_count + 16'd1;
            if (model_count == TRAILER_BYTES - 16'd1) begin
               model_crc_high = b;
            end else if (model_count >= TRAILER_BYTES) begin
               res.kind = KIND_END;
               res.status = ({model_crc_high, b} == model_crc) ? STATUS_GOOD : STATUS_CRC_BAD;
               res.last = 1'b1;
               produce = 1'b1;
               restart_hunt();
            end
         end
         default: begin
            // hunting for four zeros, everything else dropped
            model_phase = PH_HUNT;
            if (b == 8'h00) begin
               model_zero_run = model_zero_run + 3'd1;
               if (model_zero_run >= PREAMBLE_ZEROS) begin
                  model_zero_run = '0;
                  model_phase = PH_LEN;
                  model_count = '0;
                  model_length = '0;
               end
            end else begin
               model_zero_run = '0;
            end
         end
      endcase
      if (produce) expected_outputs.insert(expected_outputs.size(), res);
   endfunction

   // every accepted request feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_splitter_byte(req_tdata, req_tuser);
      end
   end

   // ---------------------------------------------------------------------
   // response side: stall pattern and checker
   // ---------------------------------------------------------------------

   // random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (rsp_hold_len != 0) begin
         hold_left <= rsp_hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // compare each accepted response with the oldest expectation, field by field
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %0h %0h %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            expected_head = expected_outputs.pop_front();
            if (rsp_tdata !== expected_head.out_byte) begin
               $display("%0t: out_byte mismatch: expected %0h, actual %0h",
                        $time, expected_head.out_byte, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[1:0] !== expected_head.kind) begin
               $display("%0t: kind mismatch: expected %0d, actual %0d",
                        $time, expected_head.kind, rsp_tuser[1:0]);
               mismatch_count++;
            end
            if (rsp_tuser[3:2] !== expected_head.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, expected_head.status, rsp_tuser[3:2]);
               mismatch_count++;
            end
            if (rsp_tlast !== expected_head.last) begin
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, expected_head.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_outputs.size());
      $display("length_prefixed_crc_frame_splitter regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // offer one request and hold it until the handshake; valid stays up when
   // the next request follows without a gap
   task automatic send_byte(input logic [7:0] b, input logic soc);
      while (req_idle_pct != 0 && $urandom_range(99, 0) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= soc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // stop sending, wait for every owed result, then let the pipe settle
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers back to back with the write enable held high
   task automatic write_config(input logic [ID_LEN_W-1:0] id_len,
                               input logic [MAX_LEN_W-1:0] max_len);
      csr_we <= 1'b1;
      csr_index <= CSR_IDENTITY_LENGTH;
      csr_wdata <= CSR_DATA_W'(id_len);
      @(posedge clock);
      csr_index <= CSR_MAX_DATA_LENGTH;
      csr_wdata <= CSR_DATA_W'(max_len);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_identity_length = id_len;
      cfg_max_data_length = max_len;
   endtask

   // identity packet with random content, optionally cut short
   task automatic send_connection(input int keep);
      int total;
      total = int'(cfg_identity_length) + 2;
      if (keep < total) total = keep;
      for (int i = 0; i < total; i++) send_byte(8'($urandom), i == 0);
   endtask

   // preamble, length, data and trailer; an over-long length stops after the
   // length bytes, as the splitter goes back to hunting there
   task automatic send_frame(input logic [31:0] length, input bit corrupt_crc, input int keep);
      logic [7:0] frame_q[$];
      logic [7:0] payload;
      logic [15:0] crc;
      crc = '0;
      repeat (PREAMBLE_ZEROS) frame_q.insert(frame_q.size(), 8'h00);
      for (int i = 3; i >= 0; i--) frame_q.insert(frame_q.size(), length[8*i +: 8]);
      if (length <= 32'(cfg_max_data_length)) begin
         for (int i = 0; i < int'(length); i++) begin
            payload = 8'($urandom);
            crc = crc16_arc_update(crc, payload);
            frame_q.insert(frame_q.size(), payload);
         end
         if (corrupt_crc) crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
         // random upper half, crc in the low half
         frame_q.insert(frame_q.size(), 8'($urandom));
         frame_q.insert(frame_q.size(), 8'($urandom));
         frame_q.insert(frame_q.size(), crc[15:8]);
         frame_q.insert(frame_q.size(), crc[7:0]);
      end
      for (int i = 0; i < frame_q.size() && i < keep; i++) send_byte(frame_q[i], 1'b0);
   endtask

   // mix of connections, line noise and frames until the request budget is spent
   task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                    input logic [ID_LEN_W-1:0] id_len,
                                    input logic [MAX_LEN_W-1:0] max_len, input int budget);
      int start_items;
      int pick;
      int sel;
      int reconnect_pct;
      logic [31:0] length;
      wait_for_drain();
      write_config(id_len, max_len);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      // long identity packets are costly, reconnect rarely then
      reconnect_pct = (id_len > 32) ? 1 : 6;
      start_items = items_sent;
      send_connection(WHOLE);
      while (items_sent - start_items < budget) begin
         pick = $urandom_range(99, 0);
         if (pick < reconnect_pct) begin
            // a quarter of the reconnects are cut short
            send_connection(($urandom_range(3, 0) == 0) ?
                            int'($urandom_range(int'(id_len) + 1, 1)) : WHOLE);
         end else if (pick < 16) begin
            // noise between frames, zeros included so partial preambles occur
            repeat ($urandom_range(6, 1)) begin
               send_byte(($urandom_range(2, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 1)), 1'b0);
            end
         end else begin
            if ($urandom_range(3, 0) == 0) send_byte(8'($urandom_range(255, 1)), 1'b0);
            sel = $urandom_range(99, 0);
            if (sel < 5) begin
               length = {8'($urandom_range(255, 1)), 24'($urandom)};
            end else if (sel < 10) begin
               length = 32'(max_len) + 32'($urandom_range(3, 1));
            end else if (sel < 16) begin
               length = 32'd0;
            end else if (sel < 20) begin
               length = 32'($urandom_range(64, 13));
            end else begin
               length = 32'($urandom_range(12, 1));
            end
            // some bad crcs, some frames broken off partway
            send_frame(length, $urandom_range(9, 0) == 0,
                       ($urandom_range(19, 0) == 0) ? int'($urandom_range(12, 1)) : WHOLE);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // shortest identity packet, dropped noise, long zero run into a zero
   // length frame, then an over-long length
   task automatic test_identity_and_framing();
      wait_for_drain();
      write_config(8'd0, 16'd4);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      // eight zeros: preamble plus a length of zero, crc stays zero
      send_frame(32'd0, 1'b0, WHOLE);
      send_frame(32'd5, 1'b0, WHOLE);
   endtask

   // identity length lowered while a packet is in flight: the next byte ends it
   task automatic test_identity_length_change();
      wait_for_drain();
      write_config(8'd3, 16'd4);
      send_byte(8'h5A, 1'b1);
      send_byte(8'hA5, 1'b0);
      wait_for_drain();
      write_config(8'd0, 16'd4);
      send_byte(8'h3C, 1'b0);
   endtask

   // receiver holds off while a frame streams in, so the block fills and
   // pushes back on its input
   task automatic test_receiver_holdoff();
      wait_for_drain();
      write_config(8'd2, 16'd64);
      rsp_hold_len <= HOLD_CYCLES;
      @(posedge clock);
      rsp_hold_len <= 0;
      send_connection(WHOLE);
      send_frame(32'd40, 1'b0, WHOLE);
   endtask

   // random streams under each idling pattern and several register settings
   task automatic test_random_streams();
      run_traffic_phase(0, 0, IDENTITY_LENGTH_RESET, MAX_DATA_LENGTH_RESET, 100);
      run_traffic_phase(62, 0, 8'd255, 16'hFFFF, 320);
      run_traffic_phase(0, 62, 8'd0, 16'd0, 50);
      run_traffic_phase(24, 24, 8'($urandom_range(20, 1)), 16'($urandom_range(60, 8)), 90);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_and_framing();
      test_identity_length_change();
      test_receiver_holdoff();
      test_random_streams();
      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("length_prefixed_crc_frame_splitter regression: pass");
      end else begin
         $display("length_prefixed_crc_frame_splitter regression: fail");
      end
      $finish;
   end

endmodule
